// ===== rtl/top_k_pair_keeper_with_mean_unit_defines.svh =====
// Assertion macros for the top-k pair keeper and its checker.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef TOP_K_PAIR_KEEPER_WITH_MEAN_UNIT_DEFINES_SVH
`define TOP_K_PAIR_KEEPER_WITH_MEAN_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TKPK_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tkpk: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TKPK_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tkpk: next-cycle check failed");

`endif

// ===== rtl/tkpk_pkg.sv =====
// Shared constants and types for the top-k pair keeper.
// No dependencies; imported by every module of the block.
package tkpk_pkg;

   localparam int DIST_W          = 20;
   localparam int LEN_W           = 5;
   localparam int MAX_LEN_DEFAULT = 16;
   localparam logic [LEN_W-1:0] LEN_RESET = 5'd8;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_OFFER  = 2'd1;
   localparam logic [1:0] OP_REPORT = 2'd2;

   localparam int REQ_DATA_W = 2 * DIST_W;
   localparam int RSP_DATA_W = ((DIST_W + 7) / 8) * 8;

   typedef struct packed {
      logic busy;
      logic done;
   } tkpk_div_status_type;

endpackage

// ===== rtl/tkpk_cell.sv =====
// One entry of the sorted pair list: compares its distance with the offer
// and keeps, takes the offer, or takes its left neighbor. Uses tkpk_pkg.
module tkpk_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic                        insert,
   input  logic                        active,
   input  logic                        is_last,
   input  logic [tkpk_pkg::DIST_W-1:0] new_geo,
   input  logic [tkpk_pkg::DIST_W-1:0] new_col,
   input  logic [tkpk_pkg::DIST_W-1:0] prev_geo,
   input  logic [tkpk_pkg::DIST_W-1:0] prev_col,
   input  logic                        prev_ge,
   output logic [tkpk_pkg::DIST_W-1:0] geo,
   output logic [tkpk_pkg::DIST_W-1:0] col,
   output logic                        ge
);
   import tkpk_pkg::*;

   logic [DIST_W-1:0] geo_ff, geo_in;
   logic [DIST_W-1:0] col_ff, col_in;

   assign ge  = (geo_ff >= new_geo);
   assign geo = geo_ff;
   assign col = col_ff;

   always_comb begin
      geo_in = geo_ff;
      col_in = col_ff;
      if (clear) begin
         geo_in = '0;
         col_in = '0;
      end else if (insert && active) begin
         if (!prev_ge) begin
            // The offer lands further left, so this entry shifts right.
            geo_in = prev_geo;
            col_in = prev_col;
         end else if (!ge || is_last) begin
            geo_in = new_geo;
            col_in = new_col;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_ff <= '0;
         col_ff <= '0;
      end else begin
         geo_ff <= geo_in;
         col_ff <= col_in;
      end
   end

endmodule

// ===== rtl/tkpk_div.sv =====
// Restoring divider, one quotient bit per cycle, for the mean report.
// Holds its quotient until acknowledged. Uses tkpk_pkg.
module tkpk_div #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             ack,
   input  logic [NUM_W-1:0]                 num,
   input  logic [DEN_W-1:0]                 den,
   output tkpk_pkg::tkpk_div_status_type    status,
   output logic [tkpk_pkg::DIST_W-1:0]      quotient
);
   import tkpk_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             qbit;

   assign shifted = {rem_ff, num_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign qbit    = (shifted >= {1'b0, den_ff});

   assign status.busy = (state_ff == ST_RUN);
   assign status.done = (state_ff == ST_DONE);
   assign quotient    = num_ff[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  num_ff   <= num;
                  den_ff   <= den;
                  rem_ff   <= '0;
                  cnt_ff   <= CNT_W'(NUM_W);
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               // Quotient bits shift in where the dividend bits leave.
               num_ff <= {num_ff[NUM_W-2:0], qbit};
               rem_ff <= qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (ack) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/top_k_pair_keeper_with_mean_unit.sv =====
// Top-k pair keeper: a descending list of up to MAX_LEN (geometric, color)
// distance pairs held in a row of compare-and-shift cells, with a running
// color sum and a mean report. Clears and offers leave the divider free,
// so one can be accepted every cycle while no report is in progress. A
// report runs the restoring divider, one quotient bit per cycle:
// req_tready is low while it runs and until its quotient is taken into
// the output register, and longer while an earlier result still sits in
// the output register. A write of the length register clears the list
// and the sum in the same cycle; the list comes out of reset cleared,
// with no sweep. Uses tkpk_pkg, tkpk_cell and tkpk_div.
module top_k_pair_keeper_with_mean_unit #(
   parameter int MAX_LEN = tkpk_pkg::MAX_LEN_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request: tdata = geometric_distance [19:0], color_distance [39:20].
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tkpk_pkg::REQ_DATA_W-1:0] req_tdata,
   // Request kind: opcode [1:0].
   input  logic [1:0]                      req_tuser,
   // Result: tdata = mean_color_distance [19:0], zero fill above.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tkpk_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Length register write: list_length [4:0].
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tkpk_pkg::LEN_W-1:0]      csr_data
);
   import tkpk_pkg::*;

   localparam int KW    = $clog2(MAX_LEN + 1);
   localparam int IW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int SUMW  = DIST_W + $clog2(MAX_LEN);
   localparam int CMPW  = (KW > LEN_W) ? KW : LEN_W;

   logic [LEN_W-1:0]  list_length_ff;
   logic [SUMW-1:0]   sum_ff, sum_in;
   logic              rsp_valid_ff;
   logic [DIST_W-1:0] rsp_data_ff;

   logic [CMPW-1:0]   len_ext;
   logic [KW-1:0]     k_eff;
   logic [IW-1:0]     last_idx;

   logic              accept;
   logic              csr_write;
   logic              do_clear;
   logic              do_offer;
   logic              do_report;
   logic              dropped;
   logic              insert;
   logic [DIST_W-1:0] req_geo;
   logic [DIST_W-1:0] req_col;

   logic [DIST_W-1:0] cell_geo [MAX_LEN];
   logic [DIST_W-1:0] cell_col [MAX_LEN];
   logic              cell_ge  [MAX_LEN];

   tkpk_div_status_type div_status;
   logic [DIST_W-1:0]   div_quotient;
   logic                rsp_free;
   logic                div_ack;

   assign req_geo   = req_tdata[DIST_W-1:0];
   assign req_col   = req_tdata[2*DIST_W-1:DIST_W];

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign req_tready = !div_status.busy && !div_status.done;
   assign accept     = req_tvalid && req_tready;
   assign do_clear   = accept && (req_tuser == OP_CLEAR);
   assign do_offer   = accept && (req_tuser == OP_OFFER);
   assign do_report  = accept && (req_tuser == OP_REPORT);

   // Effective length: zero counts as one, anything past MAX_LEN as MAX_LEN.
   always_comb begin
      len_ext = CMPW'(list_length_ff);
      if (len_ext == '0) begin
         k_eff = KW'(1);
      end else if (len_ext > CMPW'(MAX_LEN)) begin
         k_eff = KW'(MAX_LEN);
      end else begin
         k_eff = KW'(len_ext);
      end
      last_idx = IW'(k_eff - KW'(1));
   end

   assign dropped = (req_geo < cell_geo[last_idx]);
   assign insert  = do_offer && !dropped;

   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      logic [DIST_W-1:0] left_geo;
      logic [DIST_W-1:0] left_col;
      logic              left_ge;

      if (i == 0) begin : g_head
         // Nothing sits left of the head, so it never shifts in.
         assign left_geo = '0;
         assign left_col = '0;
         assign left_ge  = 1'b1;
      end else begin : g_body
         assign left_geo = cell_geo[i-1];
         assign left_col = cell_col[i-1];
         assign left_ge  = cell_ge[i-1];
      end

      tkpk_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (do_clear || csr_write),
         .insert   (insert),
         .active   (IW'(i) <= last_idx),
         .is_last  (IW'(i) == last_idx),
         .new_geo  (req_geo),
         .new_col  (req_col),
         .prev_geo (left_geo),
         .prev_col (left_col),
         .prev_ge  (left_ge),
         .geo      (cell_geo[i]),
         .col      (cell_col[i]),
         .ge       (cell_ge[i])
      );
   end

   always_comb begin
      sum_in = sum_ff;
      if (do_clear || csr_write) begin
         sum_in = '0;
      end else if (insert) begin
         sum_in = sum_ff - SUMW'(cell_col[last_idx]) + SUMW'(req_col);
      end
   end

   tkpk_div #(
      .NUM_W (SUMW),
      .DEN_W (KW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (do_report),
      .ack      (div_ack),
      .num      (sum_ff),
      .den      (k_eff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign div_ack  = div_status.done && rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         list_length_ff <= LEN_RESET;
         sum_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         if (csr_write) begin
            list_length_ff <= csr_data;
         end
         if (div_ack) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_ack) begin
         rsp_data_ff <= div_quotient;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

endmodule

// ===== rtl/tkpk_checker.sv =====
// Port-level checks for the top-k pair keeper, bound to the top level.
// Uses tkpk_pkg and the macros in top_k_pair_keeper_with_mean_unit_defines.svh.
`include "top_k_pair_keeper_with_mean_unit_defines.svh"

module tkpk_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [1:0]                      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tkpk_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tkpk_pkg::*;

   logic report_taken;

   assign report_taken = req_tvalid && req_tready && (req_tuser == OP_REPORT);

   // A stalled result keeps its value.
   `TKPK_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // A report occupies the divider, so the next request must wait.
   `TKPK_ASSERT_NEXT(a_report_blocks, report_taken, !req_tready)

   // A new result only comes out of the divider, while requests were held off.
   `TKPK_ASSERT_IMP(a_rsp_from_div, $rose(rsp_tvalid), $past(!req_tready))

endmodule

bind top_k_pair_keeper_with_mean_unit tkpk_checker u_tkpk_checker (.*);
